// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the sorted_breakpoint_table_core design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define SBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off in reset.
`define SBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sbt_pkg.sv
// ----------------------------------------------------------------------------
// sbt_pkg
// Types and constants of the sorted breakpoint table.
// ----------------------------------------------------------------------------
package sbt_pkg;

	// Width of a breakpoint or program counter address.
	localparam int ADDR_W = 64;

	// Width of the reported entry count and of the capacity register.
	localparam int CNT_OUT_W = 7;

	// Capacity register value after reset.
	localparam logic [CNT_OUT_W-1:0] MAX_ENTRIES_RST = 7'd64;

	// Command codes of a request beat.
	typedef enum logic [1:0] {
		OP_CHECK  = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	// Result of one command, handed from the sequencer to the output register.
	typedef struct packed {
		logic                 hit;
		logic                 status;
		logic [CNT_OUT_W-1:0] entry_count;
	} sbt_result_t;

endpackage

// File: design/sbt_ifs.sv
// ----------------------------------------------------------------------------
// sbt_ifs
// Valid/ready channels of the sorted breakpoint table.
// ----------------------------------------------------------------------------

// Command channel: opcode and address.
interface sbt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [63:0] address;

	modport source (output valid, output opcode, output address, input ready);
	modport sink   (input valid, input opcode, input address, output ready);
endinterface

// Response channel: hit flag, status and entry count.
interface sbt_rsp_if;
	logic       valid;
	logic       ready;
	logic       hit;
	logic       status;
	logic [6:0] entry_count;

	modport source (output valid, output hit, output status, output entry_count, input ready);
	modport sink   (input valid, input hit, input status, input entry_count, output ready);
endinterface

// Configuration write channel: capacity limit.
interface sbt_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] max_entries;

	modport source (output valid, output max_entries, input ready);
	modport sink   (input valid, input max_entries, output ready);
endinterface

// File: design/sbt_mem.sv
// ----------------------------------------------------------------------------
// sbt_mem
// Breakpoint storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sbt_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [sbt_pkg::ADDR_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [sbt_pkg::ADDR_W-1:0] rdata
);
	import sbt_pkg::*;

	logic [ADDR_W-1:0] mem [DEPTH];

	// A read of the entry written in the same cycle returns the new data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/sbt_seq.sv
// ----------------------------------------------------------------------------
// sbt_seq
// Command sequencer: scans, shifts and rewrites the table one entry a cycle.
// ----------------------------------------------------------------------------
module sbt_seq #(
	parameter int DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sbt_req_if.sink                       req,
	input  logic [sbt_pkg::CNT_OUT_W-1:0] max_entries,
	output logic                          res_valid,
	input  logic                          res_ready,
	output sbt_pkg::sbt_result_t          res
);
	import sbt_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
	localparam logic [CW-1:0] ONE = CW'(1);
	localparam logic [CW-1:0] TWO = CW'(2);
	localparam logic [EW-1:0] DEPTH_E = EW'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_SHIFT_UP,
		S_SHIFT_DN,
		S_RECALC,
		S_DONE
	} state_t;

	state_t            state_q, state_d;
	opcode_t           op_q, op_d;
	logic [CW-1:0]     idx_q, idx_d;
	logic [CW-1:0]     ins_q, ins_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     cursor_q, cursor_d;
	logic [ADDR_W-1:0] last_pc_q, last_pc_d;
	logic [ADDR_W-1:0] key_q, key_d;
	logic              hit_q, hit_d;
	logic              status_q, status_d;

	logic [CW-1:0]     rd_idx;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [ADDR_W-1:0] wdata;
	logic [ADDR_W-1:0] rdata;

	logic              in_range;
	logic              key_eq;
	logic              full;
	logic [EW-1:0]     count_e;
	opcode_t           req_op;

	sbt_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_idx[AW-1:0]),
		.rdata (rdata)
	);

	// Compare terms on the entry under the scan index.
	assign req_op   = opcode_t'(req.opcode);
	assign in_range = idx_q < count_q;
	assign key_eq   = in_range && (rdata == key_q);
	assign count_e  = EW'(count_q);
	assign full     = (count_e >= EW'(max_entries)) || (count_e >= DEPTH_E);

	assign req.ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res.hit         = hit_q;
	assign res.status      = status_q;
	assign res.entry_count = count_e[CNT_OUT_W-1:0];

	// Next state, memory port and read address for the following cycle.
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		idx_d     = idx_q;
		ins_d     = ins_q;
		count_d   = count_q;
		cursor_d  = cursor_q;
		last_pc_d = last_pc_q;
		key_d     = key_q;
		hit_d     = hit_q;
		status_d  = status_q;
		rd_idx    = idx_q;
		we        = 1'b0;
		waddr     = idx_q[AW-1:0];
		wdata     = key_q;

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					op_d     = req_op;
					key_d    = req.address;
					hit_d    = 1'b0;
					status_d = 1'b0;
					unique case (req_op)
						OP_CHECK: begin
							// A backward move restarts the search at the front.
							if (req.address < last_pc_q) begin
								idx_d  = '0;
								rd_idx = '0;
							end else begin
								idx_d  = cursor_q;
								rd_idx = cursor_q;
							end
							state_d = S_FIND;
						end
						OP_ADD, OP_REMOVE: begin
							idx_d   = '0;
							rd_idx  = '0;
							state_d = S_FIND;
						end
						OP_CLEAR: begin
							count_d  = '0;
							cursor_d = '0;
							state_d  = S_DONE;
						end
					endcase
				end
			end

			S_FIND: begin
				// Walk to the first entry not below the key.
				if (in_range && (rdata < key_q)) begin
					idx_d  = CW'(idx_q + ONE);
					rd_idx = CW'(idx_q + ONE);
				end else begin
					unique case (op_q)
						OP_CHECK: begin
							cursor_d  = idx_q;
							last_pc_d = key_q;
							hit_d     = key_eq;
							state_d   = S_DONE;
						end
						OP_ADD: begin
							if (key_eq) begin
								state_d = S_DONE;
							end else if (full) begin
								status_d = 1'b1;
								state_d  = S_DONE;
							end else begin
								ins_d   = idx_q;
								idx_d   = count_q;
								rd_idx  = CW'(count_q - ONE);
								state_d = S_SHIFT_UP;
							end
						end
						OP_REMOVE: begin
							if (key_eq) begin
								rd_idx  = CW'(idx_q + ONE);
								state_d = S_SHIFT_DN;
							end else begin
								state_d = S_DONE;
							end
						end
						OP_CLEAR: begin
							state_d = S_DONE;
						end
					endcase
				end
			end

			S_SHIFT_UP: begin
				// Move entries up by one from the top, then drop in the new key.
				we = 1'b1;
				if (idx_q != ins_q) begin
					wdata  = rdata;
					idx_d  = CW'(idx_q - ONE);
					rd_idx = CW'(idx_q - TWO);
				end else begin
					count_d = CW'(count_q + ONE);
					idx_d   = '0;
					rd_idx  = '0;
					state_d = S_RECALC;
				end
			end

			S_SHIFT_DN: begin
				// Move entries down by one over the removed slot.
				if (CW'(idx_q + ONE) < count_q) begin
					we     = 1'b1;
					wdata  = rdata;
					idx_d  = CW'(idx_q + ONE);
					rd_idx = CW'(idx_q + TWO);
				end else begin
					count_d = CW'(count_q - ONE);
					idx_d   = '0;
					rd_idx  = '0;
					state_d = S_RECALC;
				end
			end

			S_RECALC: begin
				// Cursor goes to the first entry above the last checked pc.
				if (in_range && (rdata <= last_pc_q)) begin
					idx_d  = CW'(idx_q + ONE);
					rd_idx = CW'(idx_q + ONE);
				end else begin
					cursor_d = idx_q;
					state_d  = S_DONE;
				end
			end

			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			cursor_q  <= '0;
			last_pc_q <= '0;
			hit_q     <= 1'b0;
			status_q  <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			cursor_q  <= cursor_d;
			last_pc_q <= last_pc_d;
			hit_q     <= hit_d;
			status_q  <= status_d;
		end
	end

	// Payload of the command under work needs no reset.
	always_ff @(posedge clk) begin
		op_q  <= op_d;
		idx_q <= idx_d;
		ins_q <= ins_d;
		key_q <= key_d;
	end

endmodule

// File: design/sorted_breakpoint_table_core.sv
// ----------------------------------------------------------------------------
// sorted_breakpoint_table_core
// Sorted breakpoint table with a search cursor, check/add/remove/clear.
//
//   Channel  Dir  Beat carries
//   req      in   opcode, address
//   rsp      out  hit, status, entry_count
//   cfg      in   max_entries
//
// One command is in work at a time; the memory read port visits one entry per
// cycle. A check, a duplicate or full add and an absent remove search, then
// answer; clear answers at once. An inserting add searches, shifts entries up
// and rescans for the cursor; a deleting remove searches, shifts entries down
// and rescans likewise. Reset empties the table; entries are undefined until
// written. A held response lets one more command run, whose result then stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_breakpoint_table_core #(
	parameter int DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	sbt_req_if.sink  req,
	sbt_rsp_if.source rsp,
	sbt_cfg_if.sink  cfg
);
	import sbt_pkg::*;

	logic [CNT_OUT_W-1:0] max_entries_q;
	logic                 rsp_valid_q;
	sbt_result_t          rsp_q;
	sbt_result_t          res;
	logic                 res_valid;
	logic                 res_ready;

	sbt_seq #(
		.DEPTH (DEPTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.max_entries (max_entries_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// Capacity register, written by any cfg beat.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
		end else if (cfg.valid) begin
			max_entries_q <= cfg.max_entries;
		end
	end

	// Output register between the sequencer and the response channel.
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_q.hit;
	assign rsp.status      = rsp_q.status;
	assign rsp.entry_count = rsp_q.entry_count;

	// A command beat starts work, so the next one must wait.
	`SBT_ASSERT_NEXT(a_busy_after_req, clk, arst_n, req.valid && req.ready, !req.ready, "command accepted while busy")

	// Only a check hits and only an add reports full, never both at once.
	`SBT_ASSERT_NOW(a_hit_xor_full, clk, arst_n, res_valid, !(res.hit && res.status), "hit and full together")

	// A result taken from the sequencer shows up on the response channel.
	`SBT_ASSERT_NEXT(a_result_shown, clk, arst_n, res_valid && res_ready, rsp.valid, "result lost")

endmodule
